FILE: rtl/tpr_pkg.sv
// Shared types, codes and constants for the tree pair relation block.
// Used by every module of the block; depends on nothing.

package tpr_pkg;

   // default depth of the parent table
   localparam int MAX_NODE_COUNT = 256;

   // bias in unsigned Q1.8
   localparam logic [8:0] BIAS_ONE  = 9'd256;
   localparam logic [8:0] BIAS_HALF = 9'd128;
   localparam logic [8:0] BIAS_LOW  = 9'd77;
   localparam logic [8:0] BIAS_NONE = 9'd0;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REL_SELF   = 3'd0,
      REL_PARENT = 3'd1,
      REL_SIB    = 3'd2,
      REL_ANC    = 3'd3,
      REL_DESC   = 3'd4,
      REL_UNREL  = 3'd5
   } rel_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RD_J,
      S_CHK_SIB,
      S_WALK
   } state_type;

   // result of the shared signed compare unit
   typedef struct packed {
      logic eq;
      logic lt;
   } cmp_res_type;

   // attention is blocked for descendant and unrelated pairs
   function automatic logic rel_mask(input rel_type rel);
      logic m;
      unique case (rel)
         REL_DESC, REL_UNREL: m = 1'b1;
         default:             m = 1'b0;
      endcase
      return m;
   endfunction

   function automatic logic [8:0] rel_bias(input rel_type rel);
      logic [8:0] b;
      unique case (rel)
         REL_SELF, REL_PARENT, REL_SIB: b = BIAS_ONE;
         REL_ANC, REL_DESC:             b = BIAS_HALF;
         default:                       b = BIAS_LOW;
      endcase
      return b;
   endfunction

endpackage

FILE: rtl/tpr_cmp.sv
// Shared signed 9-bit compare unit used for every parent, sibling and walk check.
// Depends on tpr_pkg for the result struct.

module tpr_cmp (
   input  logic signed [8:0]   a,
   input  logic signed [8:0]   b,
   output tpr_pkg::cmp_res_type res
);

   // equality and signed less-than; a root (-1) sits below every index
   assign res.eq = (a == b);
   assign res.lt = (a < b);

endmodule

FILE: rtl/tpr_table.sv
// Parent table memory: one write port, one read port with registered read data.
// Depends on tpr_pkg for the default depth.

module tpr_table #(
   parameter  int Depth = tpr_pkg::MAX_NODE_COUNT,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AddrW-1:0]        wr_addr,
   input  logic signed [8:0]       wr_data,
   input  logic [AddrW-1:0]        rd_addr,
   output logic signed [8:0]       rd_data
);

   logic signed [8:0] mem [Depth];
   logic signed [8:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data follows the address in the next cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tree_pair_relation_mask_bias.sv
// Clear, append, unused opcode, self and out-of-range queries answer in the next
// cycle and busy stays low, so such words may be issued every cycle.
// Parent, sibling and ancestor/descendant/unrelated queries hold busy; the last
// one walks up to 256 parent links from the deeper node, one table read per link.
// Reset clears the node count and the sequencer; table contents are undefined
// until appended and get no clearing pass. The receiver cannot stall results.

module tree_pair_relation_mask_bias #(
   parameter int MAX_NODE_COUNT = tpr_pkg::MAX_NODE_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_opcode,
   input  logic signed [8:0] req_parent_index,
   input  logic [7:0]        req_row_index,
   input  logic [7:0]        req_col_index,
   output logic              rsp_valid,
   output logic [2:0]        rsp_relation,
   output logic              rsp_mask_bit,
   output logic [8:0]        rsp_bias_value,
   output logic [1:0]        rsp_status,
   output logic [8:0]        rsp_count_now
);

   localparam int AddrW = (MAX_NODE_COUNT > 1) ? $clog2(MAX_NODE_COUNT) : 1;
   localparam int CntW  = $clog2(MAX_NODE_COUNT + 1);
   localparam int CmpW  = (CntW > 9) ? CntW : 9;
   localparam logic [CntW-1:0] CntMax = CntW'(MAX_NODE_COUNT);

   tpr_pkg::state_type   state_ff, state_in;
   logic [CntW-1:0]      node_total_ff, node_total_in;
   logic [7:0]           i_ff, i_in;
   logic [7:0]           j_ff, j_in;
   logic                 j_lo_ff, j_lo_in;
   logic signed [8:0]    pi_ff, pi_in;
   logic signed [8:0]    cur_ff, cur_in;
   logic [7:0]           tgt_ff, tgt_in;
   logic                 from_mem_ff, from_mem_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   tpr_pkg::rel_type     rel_ff, rel_in;
   logic                 mask_ff, mask_in;
   logic [8:0]           bias_ff, bias_in;
   tpr_pkg::status_type  status_ff, status_in;
   logic [8:0]           count_ff, count_in;

   logic                 accept;
   logic                 is_full;
   logic                 bad_parent;
   logic                 in_range;
   logic                 wr_en;
   logic [AddrW-1:0]     rd_addr;
   logic signed [8:0]    rd_data;
   logic signed [8:0]    cmp_a, cmp_b;
   logic signed [8:0]    walk_cur;
   tpr_pkg::cmp_res_type cmp_res;

   assign busy   = (state_ff != tpr_pkg::S_IDLE);
   assign accept = start && !busy;

   // admission checks against the current node count
   assign is_full    = (node_total_ff >= CntMax);
   assign bad_parent = req_parent_index[8] ? (req_parent_index != -9'sd1)
                     : (CmpW'(req_parent_index[7:0]) >= CmpW'(node_total_ff));
   assign in_range   = (CmpW'(req_row_index) < CmpW'(node_total_ff))
                    && (CmpW'(req_col_index) < CmpW'(node_total_ff));

   // walk operand comes from the register on the first step, then from the table
   assign walk_cur = from_mem_ff ? rd_data : cur_ff;

   tpr_table #(
      .Depth (MAX_NODE_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (node_total_ff[AddrW-1:0]),
      .wr_data (req_parent_index),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tpr_cmp u_cmp (
      .a   (cmp_a),
      .b   (cmp_b),
      .res (cmp_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tpr_pkg::S_IDLE: begin
            if (accept && (req_opcode == tpr_pkg::OP_QUERY) && in_range
                && (req_row_index != req_col_index)) begin
               state_in = tpr_pkg::S_RD_J;
            end
         end
         tpr_pkg::S_RD_J: begin
            state_in = cmp_res.eq ? tpr_pkg::S_IDLE : tpr_pkg::S_CHK_SIB;
         end
         tpr_pkg::S_CHK_SIB: begin
            state_in = cmp_res.eq ? tpr_pkg::S_IDLE : tpr_pkg::S_WALK;
         end
         tpr_pkg::S_WALK: begin
            if (cmp_res.eq || cmp_res.lt) begin
               state_in = tpr_pkg::S_IDLE;
            end
         end
         default: state_in = tpr_pkg::S_IDLE;
      endcase
   end

   // datapath, table access and result words
   always_comb begin
      node_total_in = node_total_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      j_lo_in       = j_lo_ff;
      pi_in         = pi_ff;
      cur_in        = cur_ff;
      tgt_in        = tgt_ff;
      from_mem_in   = from_mem_ff;
      rsp_valid_in  = 1'b0;
      rel_in        = rel_ff;
      mask_in       = mask_ff;
      bias_in       = bias_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      rd_addr       = AddrW'(req_row_index);
      cmp_a         = rd_data;
      cmp_b         = {1'b0, j_ff};

      unique case (state_ff)
         tpr_pkg::S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rel_in       = tpr_pkg::REL_SELF;
               mask_in      = 1'b0;
               bias_in      = tpr_pkg::BIAS_NONE;
               status_in    = tpr_pkg::ST_OK;
               count_in     = 9'(node_total_ff);
               case (req_opcode)
                  tpr_pkg::OP_CLEAR: begin
                     node_total_in = '0;
                     count_in      = '0;
                  end
                  tpr_pkg::OP_APPEND: begin
                     if (is_full) begin
                        status_in = tpr_pkg::ST_FULL;
                     end else if (bad_parent) begin
                        status_in = tpr_pkg::ST_RANGE;
                     end else begin
                        wr_en         = 1'b1;
                        node_total_in = node_total_ff + 1'b1;
                        count_in      = 9'(node_total_ff + 1'b1);
                     end
                  end
                  tpr_pkg::OP_QUERY: begin
                     if (!in_range) begin
                        status_in = tpr_pkg::ST_RANGE;
                        rel_in    = tpr_pkg::REL_UNREL;
                        mask_in   = 1'b1;
                     end else if (req_row_index == req_col_index) begin
                        bias_in = tpr_pkg::rel_bias(tpr_pkg::REL_SELF);
                     end else begin
                        // pair needs the table; parent of row is being read now
                        rsp_valid_in = 1'b0;
                        i_in         = req_row_index;
                        j_in         = req_col_index;
                        j_lo_in      = (req_col_index < req_row_index);
                     end
                  end
                  default: begin
                     // unused opcode: no state change; zero result fields but the current node count
                  end
               endcase
            end
         end
         tpr_pkg::S_RD_J: begin
            // parent of row arrives; parent of column is requested
            rd_addr = AddrW'(j_ff);
            cmp_a   = rd_data;
            cmp_b   = {1'b0, j_ff};
            pi_in   = rd_data;
            if (cmp_res.eq) begin
               rsp_valid_in = 1'b1;
               rel_in       = tpr_pkg::REL_PARENT;
               mask_in      = tpr_pkg::rel_mask(tpr_pkg::REL_PARENT);
               bias_in      = tpr_pkg::rel_bias(tpr_pkg::REL_PARENT);
               status_in    = tpr_pkg::ST_OK;
               count_in     = 9'(node_total_ff);
            end
         end
         tpr_pkg::S_CHK_SIB: begin
            // same parent, two roots included
            cmp_a = pi_ff;
            cmp_b = rd_data;
            if (cmp_res.eq) begin
               rsp_valid_in = 1'b1;
               rel_in       = tpr_pkg::REL_SIB;
               mask_in      = tpr_pkg::rel_mask(tpr_pkg::REL_SIB);
               bias_in      = tpr_pkg::rel_bias(tpr_pkg::REL_SIB);
               status_in    = tpr_pkg::ST_OK;
               count_in     = 9'(node_total_ff);
            end else begin
               // parents precede children, so only the higher index can descend
               cur_in      = j_lo_ff ? pi_ff : rd_data;
               tgt_in      = j_lo_ff ? j_ff : i_ff;
               from_mem_in = 1'b0;
            end
         end
         tpr_pkg::S_WALK: begin
            // one chain link per cycle; stop at the target or once below it
            cmp_a = walk_cur;
            cmp_b = {1'b0, tgt_ff};
            if (cmp_res.eq || cmp_res.lt) begin
               rsp_valid_in = 1'b1;
               status_in    = tpr_pkg::ST_OK;
               count_in     = 9'(node_total_ff);
               if (cmp_res.eq) begin
                  rel_in  = j_lo_ff ? tpr_pkg::REL_ANC : tpr_pkg::REL_DESC;
                  mask_in = !j_lo_ff;
               end else begin
                  rel_in  = tpr_pkg::REL_UNREL;
                  mask_in = 1'b1;
               end
               bias_in = cmp_res.eq ? tpr_pkg::BIAS_HALF : tpr_pkg::BIAS_LOW;
            end else begin
               rd_addr     = AddrW'(walk_cur[7:0]);
               from_mem_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tpr_pkg::S_IDLE;
         node_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_total_ff <= node_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      j_lo_ff     <= j_lo_in;
      pi_ff       <= pi_in;
      cur_ff      <= cur_in;
      tgt_ff      <= tgt_in;
      from_mem_ff <= from_mem_in;
      rel_ff      <= rel_in;
      mask_ff     <= mask_in;
      bias_ff     <= bias_in;
      status_ff   <= status_in;
      count_ff    <= count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_relation   = rel_ff;
   assign rsp_mask_bit   = mask_ff;
   assign rsp_bias_value = bias_ff;
   assign rsp_status     = status_ff;
   assign rsp_count_now  = count_ff;

endmodule

FILE: rtl/tpr_check.sv
// Port-level checks for the tree pair relation block, bound to its top level.
// Depends on tpr_pkg for opcode, status and relation codes.

module tpr_check (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [1:0]        req_opcode,
   input logic              rsp_valid,
   input logic [2:0]        rsp_relation,
   input logic              rsp_mask_bit,
   input logic [8:0]        rsp_bias_value,
   input logic [1:0]        rsp_status,
   input logic [8:0]        rsp_count_now
);

   // a clear word answers next cycle with an empty count
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_opcode == tpr_pkg::OP_CLEAR)
      |=> rsp_valid && (rsp_count_now == 9'd0))
      else $error("clear did not answer with an empty table");

   // non-query words (table updates, unused opcodes) answer next cycle and leave the block free
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_opcode != tpr_pkg::OP_QUERY)
      |=> rsp_valid && !busy)
      else $error("non-query word did not complete in one cycle");

   // the sequencer only releases with a result word
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("busy dropped without a result word");

   // mask follows the relation class
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mask_bit == ((rsp_relation == tpr_pkg::REL_DESC)
                                   || (rsp_relation == tpr_pkg::REL_UNREL))))
      else $error("mask bit disagrees with relation");

   // ancestor and descendant carry the half bias on a good query
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == tpr_pkg::ST_OK)
      && ((rsp_relation == tpr_pkg::REL_ANC) || (rsp_relation == tpr_pkg::REL_DESC))
      |-> (rsp_bias_value == tpr_pkg::BIAS_HALF))
      else $error("ancestor or descendant without half bias");

endmodule

bind tree_pair_relation_mask_bias tpr_check u_tpr_check (.*);
